@@ design/mdh_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mdh_pkg
// Shared constants, register map, state encoding and control bundles for the
// modulated delay line with cubic Hermite interpolation.
// ----------------------------------------------------------------------------
package mdh_pkg;

	// default sizing
	localparam int DEPTH_DEF       = 1024;
	localparam int CHANNELS_DEF    = 2;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF   = 12;

	// fixed formats of the control values
	localparam int CFG_BITS = 16;   // width of every config register
	localparam int LFO_BITS = 16;   // Q1.15
	localparam int LFO_FRAC = 15;
	localparam int MS_FRAC  = 12;   // Q4.12 milliseconds
	localparam int SPM_FRAC = 8;    // Q8.8 samples per ms

	// delay limits in Q4.12 ms: 3 ms .. 9 ms
	localparam logic [CFG_BITS-1:0] DELAY_MIN = 16'd12288;
	localparam logic [CFG_BITS-1:0] DELAY_MAX = 16'd36864;

	// register map
	localparam int PADDR_BITS = 4;
	localparam int PDATA_BITS = 32;
	localparam logic [1:0] REG_BASE_DELAY     = 2'd0;
	localparam logic [1:0] REG_PITCH_DEPTH    = 2'd1;
	localparam logic [1:0] REG_SAMPLES_PER_MS = 2'd2;

	localparam logic [CFG_BITS-1:0] RST_BASE_DELAY     = 16'd24576;
	localparam logic [CFG_BITS-1:0] RST_PITCH_DEPTH    = 16'd0;
	localparam logic [CFG_BITS-1:0] RST_SAMPLES_PER_MS = 16'd12288;

	// sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_DMS,
		ST_DSC,
		ST_ADDR,
		ST_RD0,
		ST_RD1,
		ST_COEF,
		ST_H1,
		ST_H2,
		ST_H3,
		ST_FIN
	} state_t;

	// addend of a Horner step
	typedef enum logic [1:0] {
		ADD_C2,
		ADD_C1,
		ADD_Y0
	} add_sel_t;

	// strobes into the read position unit
	typedef struct packed {
		logic mul;
		logic dms;
		logic dsc;
		logic addr;
	} pos_ctl_t;

	// strobes into the interpolator
	typedef struct packed {
		logic     cap;
		logic     coef;
		logic     step;
		add_sel_t add_sel;
	} interp_ctl_t;

endpackage
`default_nettype wire

@@ design/mdh_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mdh_if
// Valid/ready channels carrying input samples and interpolated results.
// ----------------------------------------------------------------------------
interface mdh_in_if #(
	parameter int SAMPLE_BITS = mdh_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          channel;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic signed [15:0]            lfo;
	logic                          frame_end;

	modport source (output valid, channel, sample_in, lfo, frame_end, input ready);
	modport sink   (input valid, channel, sample_in, lfo, frame_end, output ready);
endinterface

interface mdh_out_if #(
	parameter int SAMPLE_BITS = mdh_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, sample_out, input ready);
	modport sink   (input valid, sample_out, output ready);
endinterface
`default_nettype wire

@@ design/mdh_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mdh_ram
// Sample store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mdh_ram #(
	parameter int WIDTH = 24,
	parameter int WORDS = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(WORDS)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(WORDS)-1:0] raddr_a,
	input  wire logic [$clog2(WORDS)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem [WORDS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read ports
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule
`default_nettype wire

@@ design/mdh_pos.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mdh_pos
// Read position: modulated delay in ms, clamp, scale to samples, wrap behind
// the write pointer. One step per strobe.
// ----------------------------------------------------------------------------
module mdh_pos #(
	parameter int DEPTH     = mdh_pkg::DEPTH_DEF,
	parameter int FRAC_BITS = mdh_pkg::FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire mdh_pkg::pos_ctl_t             ctl,
	input  wire logic signed [15:0]            lfo,
	input  wire logic [15:0]                   base_delay_ms,
	input  wire logic signed [15:0]            pitch_depth,
	input  wire logic [15:0]                   samples_per_ms,
	input  wire logic [$clog2(DEPTH)-1:0]      wp,
	output logic      [$clog2(DEPTH)-1:0]      i0,
	output logic      [FRAC_BITS-1:0]          f
);
	import mdh_pkg::*;

	localparam int AW     = $clog2(DEPTH);
	localparam int PW     = AW + FRAC_BITS + 1;
	localparam int DSHIFT = MS_FRAC + SPM_FRAC - FRAC_BITS;
	localparam logic [31:0]   DMAX = 32'(DEPTH - 3) << FRAC_BITS;
	localparam logic [PW-1:0] SPAN = PW'(DEPTH) << FRAC_BITS;

	logic signed [31:0] prod_s1;
	logic [15:0]        dms_s2;
	logic [31:0]        dprod_s3;

	logic signed [31:0] prod_sh;
	logic signed [17:0] dms_sum;
	logic [15:0]        dms_clamp;
	logic [31:0]        dsh;
	logic [PW-1:0]      dcl;
	logic [PW-1:0]      rp;
	logic [PW-1:0]      rp_wrap;

	// delay in ms with clamp to the allowed window
	always_comb begin
		prod_sh = prod_s1 >>> LFO_FRAC;
		dms_sum = $signed({2'b00, base_delay_ms}) + $signed({prod_sh[16], prod_sh[16:0]});
		if (dms_sum < $signed({2'b00, DELAY_MIN})) begin
			dms_clamp = DELAY_MIN;
		end else if (dms_sum > $signed({2'b00, DELAY_MAX})) begin
			dms_clamp = DELAY_MAX;
		end else begin
			dms_clamp = dms_sum[15:0];
		end
	end

	// samples behind the write pointer, saturated, then wrapped
	always_comb begin
		dsh     = dprod_s3 >> DSHIFT;
		dcl     = (dsh > DMAX) ? PW'(DMAX) : PW'(dsh);
		rp      = (PW'(wp) << FRAC_BITS) + SPAN - dcl;
		rp_wrap = (rp >= SPAN) ? rp - SPAN : rp;
	end

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_s1 <= lfo * pitch_depth;
		end
		if (ctl.dms) begin
			dms_s2 <= dms_clamp;
		end
		if (ctl.dsc) begin
			dprod_s3 <= 32'(dms_s2) * 32'(samples_per_ms);
		end
		if (ctl.addr) begin
			i0 <= rp_wrap[FRAC_BITS +: AW];
			f  <= rp_wrap[FRAC_BITS-1:0];
		end
	end
endmodule
`default_nettype wire

@@ design/mdh_interp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mdh_interp
// Catmull-Rom interpolation: captures two neighbors and takes the other two
// from the read ports, forms the doubled coefficients, runs three Horner
// steps on one shared multiplier, then rounds and saturates.
// ----------------------------------------------------------------------------
module mdh_interp #(
	parameter int SAMPLE_BITS = mdh_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = mdh_pkg::FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire mdh_pkg::interp_ctl_t          ctl,
	input  wire logic [SAMPLE_BITS-1:0]        rd_a,
	input  wire logic [SAMPLE_BITS-1:0]        rd_b,
	input  wire logic [FRAC_BITS-1:0]          f,
	output logic signed [SAMPLE_BITS-1:0]      y
);
	import mdh_pkg::*;

	localparam int CW = SAMPLE_BITS + 4;   // coefficient width
	localparam int TW = SAMPLE_BITS + 5;   // accumulator width
	localparam logic signed [TW-1:0] YMAX = (TW'(1) <<< (SAMPLE_BITS - 1)) - TW'(1);
	localparam logic signed [TW-1:0] YMIN = -(TW'(1) <<< (SAMPLE_BITS - 1));

	logic signed [SAMPLE_BITS-1:0] ym1_q;
	logic signed [SAMPLE_BITS-1:0] y0_q;
	logic signed [CW-1:0]          c1_q;
	logic signed [CW-1:0]          c2_q;
	logic signed [TW-1:0]          t_q;

	logic signed [CW-1:0]           ym1e, y0e, y1e, y2e, d01;
	logic signed [CW-1:0]           c1, c2, c3;
	logic signed [TW+FRAC_BITS:0]   prod;
	logic signed [TW+FRAC_BITS:0]   prod_sh;
	logic signed [TW-1:0]           addend;
	logic signed [TW-1:0]           rnd;

	// doubled coefficients; y1, y2 arrive on the read ports now
	always_comb begin
		ym1e = CW'(ym1_q);
		y0e  = CW'(y0_q);
		y1e  = CW'($signed(rd_a));
		y2e  = CW'($signed(rd_b));
		d01  = y0e - y1e;
		c1   = y1e - ym1e;
		c2   = (ym1e <<< 1) - (y0e <<< 2) - y0e + (y1e <<< 2) - y2e;
		c3   = (y2e - ym1e) + (d01 <<< 1) + d01;
	end

	// one Horner step: t*f >> F with floor, plus the selected coefficient
	always_comb begin
		prod    = t_q * $signed({1'b0, f});
		prod_sh = prod >>> FRAC_BITS;
		case (ctl.add_sel)
			ADD_C2:  addend = TW'(c2_q);
			ADD_C1:  addend = TW'(c1_q);
			ADD_Y0:  addend = TW'(y0_q) <<< 1;
			default: addend = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			ym1_q <= $signed(rd_a);
			y0_q  <= $signed(rd_b);
		end
		if (ctl.coef) begin
			c1_q <= c1;
			c2_q <= c2;
			t_q  <= TW'(c3);
		end else if (ctl.step) begin
			t_q <= TW'(prod_sh) + addend;
		end
	end

	// round half up and saturate
	always_comb begin
		rnd = (t_q + TW'(1)) >>> 1;
		if (rnd > YMAX) begin
			y = YMAX[SAMPLE_BITS-1:0];
		end else if (rnd < YMIN) begin
			y = YMIN[SAMPLE_BITS-1:0];
		end else begin
			y = rnd[SAMPLE_BITS-1:0];
		end
	end
endmodule
`default_nettype wire

@@ design/modulated_delay_hermite.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// modulated_delay_hermite
// Per-channel modulated delay line with Catmull-Rom interpolation.
// A transaction runs the sequencer through the delay math, two dual-port reads
//   of the store and three Horner steps; its result then enters the output
//   register, and no new transaction is accepted until that has happened.
// Reset: store is swept to zero, every word, with ready held low;
//   config registers take their defaults, write pointer goes to zero.
// ----------------------------------------------------------------------------
module modulated_delay_hermite #(
	parameter int DEPTH       = mdh_pkg::DEPTH_DEF,
	parameter int CHANNELS    = mdh_pkg::CHANNELS_DEF,
	parameter int SAMPLE_BITS = mdh_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = mdh_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	mdh_in_if.sink                                   audio,
	mdh_out_if.source                                delayed,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [mdh_pkg::PADDR_BITS-1:0]      paddr,
	input  wire logic [mdh_pkg::PDATA_BITS-1:0]      pwdata,
	output logic      [mdh_pkg::PDATA_BITS-1:0]      prdata,
	output logic                                     pready
);
	import mdh_pkg::*;

	localparam int AW        = $clog2(DEPTH);
	localparam int MEM_WORDS = DEPTH * CHANNELS;
	localparam int MA        = $clog2(MEM_WORDS);
	localparam int CHW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	state_t state_q, state_d;

	logic [CFG_BITS-1:0] base_delay_q;
	logic [CFG_BITS-1:0] pitch_depth_q;
	logic [CFG_BITS-1:0] spm_q;

	logic [AW-1:0]                 wp_q;
	logic [MA-1:0]                 clr_q;
	logic [CHW-1:0]                ch_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [LFO_BITS-1:0]    lfo_q;
	logic                          fe_q;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;

	logic                          rdy;
	logic                          out_load;
	logic                          out_free;
	logic                          cfg_wr;
	pos_ctl_t                      pctl;
	interp_ctl_t                   ictl;
	logic                          ram_we;
	logic [MA-1:0]                 ram_waddr;
	logic [SAMPLE_BITS-1:0]        ram_wdata;
	logic [MA-1:0]                 raddr_a, raddr_b;
	logic [SAMPLE_BITS-1:0]        rdata_a, rdata_b;

	logic [AW-1:0]                 i0;
	logic [FRAC_BITS-1:0]          f;
	logic [AW-1:0]                 im1, i1, i2;
	logic [MA-1:0]                 chbase;
	logic signed [SAMPLE_BITS-1:0] y;

	// config port: writes in the access phase, reads return the register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_delay_q  <= RST_BASE_DELAY;
			pitch_depth_q <= RST_PITCH_DEPTH;
			spm_q         <= RST_SAMPLES_PER_MS;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_BASE_DELAY:     base_delay_q  <= pwdata[CFG_BITS-1:0];
				REG_PITCH_DEPTH:    pitch_depth_q <= pwdata[CFG_BITS-1:0];
				REG_SAMPLES_PER_MS: spm_q         <= pwdata[CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_BASE_DELAY:     prdata = PDATA_BITS'(base_delay_q);
			REG_PITCH_DEPTH:    prdata = PDATA_BITS'(pitch_depth_q);
			REG_SAMPLES_PER_MS: prdata = PDATA_BITS'(spm_q);
			default:            prdata = '0;
		endcase
	end

	// neighbor indices with wrap, channel region base
	always_comb begin
		im1    = (i0 == '0) ? AW'(DEPTH - 1) : i0 - AW'(1);
		i1     = (i0 == AW'(DEPTH - 1)) ? '0 : i0 + AW'(1);
		i2     = (i1 == AW'(DEPTH - 1)) ? '0 : i1 + AW'(1);
		chbase = MA'(ch_q) * MA'(DEPTH);
	end

	assign out_free = !out_valid_q || delayed.ready;

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d       = state_q;
		rdy           = 1'b0;
		out_load      = 1'b0;
		pctl          = '0;
		ictl          = '0;
		ictl.add_sel  = ADD_C2;
		ram_we        = 1'b0;
		ram_waddr     = clr_q;
		ram_wdata     = '0;
		raddr_a       = chbase + MA'(im1);
		raddr_b       = chbase + MA'(i0);
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (clr_q == MA'(MEM_WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				rdy = 1'b1;
				if (audio.valid) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				pctl.mul = 1'b1;
				state_d  = ST_DMS;
			end
			ST_DMS: begin
				pctl.dms = 1'b1;
				state_d  = ST_DSC;
			end
			ST_DSC: begin
				pctl.dsc = 1'b1;
				state_d  = ST_ADDR;
			end
			ST_ADDR: begin
				pctl.addr = 1'b1;
				state_d   = ST_RD0;
			end
			ST_RD0: begin
				state_d = ST_RD1;
			end
			ST_RD1: begin
				ictl.cap = 1'b1;
				raddr_a  = chbase + MA'(i1);
				raddr_b  = chbase + MA'(i2);
				state_d  = ST_COEF;
			end
			ST_COEF: begin
				// all reads done, the new sample may overwrite its slot
				ictl.coef = 1'b1;
				ram_we    = 1'b1;
				ram_waddr = chbase + MA'(wp_q);
				ram_wdata = x_q;
				state_d   = ST_H1;
			end
			ST_H1: begin
				ictl.step    = 1'b1;
				ictl.add_sel = ADD_C2;
				state_d      = ST_H2;
			end
			ST_H2: begin
				ictl.step    = 1'b1;
				ictl.add_sel = ADD_C1;
				state_d      = ST_H3;
			end
			ST_H3: begin
				ictl.step    = 1'b1;
				ictl.add_sel = ADD_Y0;
				state_d      = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign audio.ready = rdy;

	// clear sweep counter and write pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			wp_q  <= '0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + MA'(1);
			end
			if (state_q == ST_COEF && fe_q) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
		end
	end

	// transaction capture
	always_ff @(posedge clk) begin
		if (audio.valid && rdy) begin
			ch_q  <= (CHANNELS > 1) ? CHW'(audio.channel) : '0;
			x_q   <= audio.sample_in;
			lfo_q <= audio.lfo;
			fe_q  <= audio.frame_end;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (delayed.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= y;
		end
	end

	assign delayed.valid      = out_valid_q;
	assign delayed.sample_out = out_data_q;

	mdh_pos #(
		.DEPTH     (DEPTH),
		.FRAC_BITS (FRAC_BITS)
	) u_pos (
		.clk            (clk),
		.ctl            (pctl),
		.lfo            (lfo_q),
		.base_delay_ms  (base_delay_q),
		.pitch_depth    ($signed(pitch_depth_q)),
		.samples_per_ms (spm_q),
		.wp             (wp_q),
		.i0             (i0),
		.f              (f)
	);

	mdh_ram #(
		.WIDTH (SAMPLE_BITS),
		.WORDS (MEM_WORDS)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	mdh_interp #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_interp (
		.clk  (clk),
		.ctl  (ictl),
		.rd_a (rdata_a),
		.rd_b (rdata_b),
		.f    (f),
		.y    (y)
	);

`ifndef ASSERT_OFF
	// a finished result waits while the output register is still occupied
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && !delayed.ready) |=> state_q == ST_FIN)
		else $error("sequencer left FIN with the output register busy");

	// one transaction at a time
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(audio.valid && audio.ready) |=> !audio.ready)
		else $error("second transaction accepted while one is in flight");

	// write pointer stays inside the line
	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(wp_q) < 32'(DEPTH))
		else $error("write pointer out of range");

	// read position stays inside the line when the reads start
	a_i0_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD0) |-> 32'(i0) < 32'(DEPTH))
		else $error("read index out of range");
`endif

endmodule
`default_nettype wire
